/* rtl/core/prq_pkg.sv */
package prq_pkg;

	localparam int MAX_TASKS_DEF = 16;

	localparam int ID_W     = 8;
	localparam int PRIO_W   = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

/* rtl/core/priority_ready_queue.sv */
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid, in_ready   | op, task_id, priority_req
// output  | out       | out_valid, out_ready | status, head_valid, head_task,
//         |           |                      | head_priority, entry_count
//
// One memory read and at most one memory write per cycle walk the table one entry at a time.
// An insert walks from the tail toward its slot, and a remove walks from the head past its match.
// The queue is empty after reset, and arst_n clears all control state.
// The finished result waits in an output register. A new item is taken while it waits.
// The next result waits for out_ready only at its last cycle.
module priority_ready_queue
	import prq_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic [ID_W-1:0]     task_id,
	input  logic [PRIO_W-1:0]   priority_req,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic                head_valid,
	output logic [ID_W-1:0]     head_task,
	output logic [PRIO_W-1:0]   head_priority,
	output logic [COUNT_W-1:0]  entry_count
);

	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_INS_CMP   = 3'd1;
	localparam logic [2:0] S_INS_PUT   = 3'd2;
	localparam logic [2:0] S_REM_FIND  = 3'd3;
	localparam logic [2:0] S_REM_SHIFT = 3'd4;
	localparam logic [2:0] S_DONE      = 3'd5;

	logic [ID_W-1:0]     queued_ids_q  [MAX_TASKS];
	logic [PRIO_W-1:0]   queued_prio_q [MAX_TASKS];

	logic [2:0]          state_q, state_d;
	logic [AW-1:0]       ptr_q, ptr_d;
	logic [CW-1:0]       occ_q, occ_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic [ID_W-1:0]     req_id_q;
	logic [PRIO_W-1:0]   req_prio_q;
	logic [ID_W-1:0]     rd_id_q;
	logic [PRIO_W-1:0]   rd_prio_q;
	logic [ID_W-1:0]     head_id_q;
	logic [PRIO_W-1:0]   head_prio_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic                head_valid_q;
	logic [ID_W-1:0]     head_task_q;
	logic [PRIO_W-1:0]   head_priority_q;
	logic [COUNT_W-1:0]  entry_count_q;

	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [ID_W-1:0]     wr_id;
	logic [PRIO_W-1:0]   wr_prio;
	logic [AW-1:0]       rd_addr;
	logic                load_out;
	logic                at_last;

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign head_valid    = head_valid_q;
	assign head_task     = head_task_q;
	assign head_priority = head_priority_q;
	assign entry_count   = entry_count_q;

	assign at_last = ((CW'(ptr_q) + 1'b1) == occ_q);

	always_comb begin
		state_d      = state_q;
		ptr_d        = ptr_q;
		occ_d        = occ_q;
		res_status_d = res_status_q;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_id        = req_id_q;
		wr_prio      = req_prio_q;
		rd_addr      = '0;
		load_out     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op == OP_INSERT) begin
						if (occ_q == CW'(MAX_TASKS)) begin
							res_status_d = ST_FULL;
							state_d      = S_DONE;
						end else if (occ_q == '0) begin
							wr_en        = 1'b1;
							wr_id        = task_id;
							wr_prio      = priority_req;
							occ_d        = occ_q + 1'b1;
							res_status_d = ST_OK;
							state_d      = S_DONE;
						end else begin
							rd_addr = AW'(occ_q - 1'b1);
							ptr_d   = AW'(occ_q - 1'b1);
							state_d = S_INS_CMP;
						end
					end else begin
						if (occ_q == '0) begin
							res_status_d = ST_NOT_FOUND;
							state_d      = S_DONE;
						end else begin
							ptr_d   = '0;
							state_d = S_REM_FIND;
						end
					end
				end
			end
			S_INS_CMP: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q + 1'b1;
				if (rd_prio_q >= req_prio_q) begin
					wr_id   = rd_id_q;
					wr_prio = rd_prio_q;
					if (ptr_q == '0) begin
						state_d = S_INS_PUT;
					end else begin
						rd_addr = ptr_q - 1'b1;
						ptr_d   = ptr_q - 1'b1;
					end
				end else begin
					occ_d        = occ_q + 1'b1;
					res_status_d = ST_OK;
					state_d      = S_DONE;
				end
			end
			S_INS_PUT: begin
				wr_en        = 1'b1;
				occ_d        = occ_q + 1'b1;
				res_status_d = ST_OK;
				state_d      = S_DONE;
			end
			S_REM_FIND: begin
				if (rd_id_q == req_id_q) begin
					res_status_d = ST_OK;
					if (at_last) begin
						occ_d   = occ_q - 1'b1;
						state_d = S_DONE;
					end else begin
						rd_addr = ptr_q + 1'b1;
						ptr_d   = ptr_q + 1'b1;
						state_d = S_REM_SHIFT;
					end
				end else if (at_last) begin
					res_status_d = ST_NOT_FOUND;
					state_d      = S_DONE;
				end else begin
					rd_addr = ptr_q + 1'b1;
					ptr_d   = ptr_q + 1'b1;
				end
			end
			S_REM_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q - 1'b1;
				wr_id   = rd_id_q;
				wr_prio = rd_prio_q;
				if (at_last) begin
					occ_d   = occ_q - 1'b1;
					state_d = S_DONE;
				end else begin
					rd_addr = ptr_q + 1'b1;
					ptr_d   = ptr_q + 1'b1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ptr_q        <= '0;
			occ_q        <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			ptr_q        <= ptr_d;
			occ_q        <= occ_d;
			res_status_q <= res_status_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_id_q   <= task_id;
			req_prio_q <= priority_req;
		end
		if (wr_en) begin
			queued_ids_q[wr_addr]  <= wr_id;
			queued_prio_q[wr_addr] <= wr_prio;
		end
		rd_id_q   <= queued_ids_q[rd_addr];
		rd_prio_q <= queued_prio_q[rd_addr];
		if (wr_en && (wr_addr == '0)) begin
			head_id_q   <= wr_id;
			head_prio_q <= wr_prio;
		end
		if (load_out) begin
			status_q      <= res_status_q;
			head_valid_q  <= (occ_q != '0);
			head_task_q   <= (occ_q != '0) ? head_id_q : '0;
			head_priority_q <= (occ_q != '0) ? head_prio_q : '0;
			entry_count_q <= COUNT_W'(occ_q);
		end
	end

endmodule

/* rtl/core/prq_checker.sv */
module prq_checker
	import prq_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                op,
	input logic [ID_W-1:0]     task_id,
	input logic [PRIO_W-1:0]   priority_req,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic                head_valid,
	input logic [ID_W-1:0]     head_task,
	input logic [PRIO_W-1:0]   head_priority,
	input logic [COUNT_W-1:0]  entry_count
);

	// A waiting result must not change before it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(head_valid)
			&& $stable(head_task) && $stable(head_priority) && $stable(entry_count))
		else $error("result changed while stalled");

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new item taken while busy");

	// A full queue reports its capacity and a valid head.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> head_valid
			&& (entry_count == COUNT_W'(MAX_TASKS)))
		else $error("full status with wrong count or head");

	// An empty queue reports zero entries and a cleared head.
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !head_valid |-> (entry_count == '0) && (head_task == '0)
			&& (head_priority == '0))
		else $error("empty queue with nonzero fields");

endmodule

bind priority_ready_queue prq_checker #(.MAX_TASKS(MAX_TASKS)) u_prq_checker (.*);
